### rtl/gbts_pkg.sv
package gbts_pkg;

    // Default geometry of the store
    localparam int CAPACITY_DEF = 1024;
    localparam int READ_MAX_DEF = 64;

    // Fixed field widths
    localparam int MODE_W = 2;
    localparam int POS_W  = 11;
    localparam int CNT_W  = 11;
    localparam int BYTE_W = 8;
    localparam int STAT_W = 2;

    // Command modes
    localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ERASE  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_READ   = 2'd2;

    // Result status codes
    localparam logic [STAT_W-1:0] ST_DONE = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL = 2'd1;
    localparam logic [STAT_W-1:0] ST_NONE = 2'd2;

    // Command word
    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [POS_W-1:0]  position;
        logic [CNT_W-1:0]  count;
        logic [BYTE_W-1:0] byte_in;
    } t_cmd;

    // Result word
    typedef struct packed {
        logic [BYTE_W-1:0] byte_out;
        logic [STAT_W-1:0] status;
        logic              last;
        logic [POS_W-1:0]  text_length;
    } t_rsp;

    // Commands from controller to datapath
    typedef struct packed {
        logic              load_cmd;
        logic              decide;
        logic              move_step;
        logic              ins_write;
        logic              erase_set;
        logic              rd_issue;
        logic              rsp_load;
        logic              rsp_data;
        logic [STAT_W-1:0] rsp_status;
    } t_ctl;

    // Status from datapath to controller
    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic              full;
        logic              past;
        logic              cnt_zero;
        logic              at_target;
        logic              rd_last;
        logic              out_free;
    } t_sts;

endpackage

### rtl/gbts_stream_if.sv
interface gbts_stream_if #(
    parameter type t_data = logic
);
    logic  valid;
    logic  ready;
    t_data data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### rtl/gbts_dp.sv
module gbts_dp #(
    parameter int CAPACITY = 1024,
    parameter int READ_MAX = 64
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  gbts_pkg::t_cmd i_cmd,
    input  gbts_pkg::t_ctl i_ctl,
    output gbts_pkg::t_sts o_sts,
    input  logic           i_out_ready,
    output logic           o_out_valid,
    output gbts_pkg::t_rsp o_out
);
    import gbts_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int PW = $clog2(CAPACITY + 1);
    localparam int WW = ((PW > POS_W) ? PW : POS_W) + 1;
    localparam int RW = $clog2(READ_MAX + 1);

    // Text memory: one write and one registered read per cycle
    logic [BYTE_W-1:0] r_mem [CAPACITY];
    logic [BYTE_W-1:0] r_rd_data;

    // Gap pointers and text length
    logic [PW-1:0] r_gs;
    logic [PW-1:0] r_ge;
    logic [PW-1:0] r_len;

    // Latched command and derived values
    t_cmd          r_cmd;
    logic [PW-1:0] r_target;
    logic [PW-1:0] r_ecnt;
    logic [PW-1:0] r_lp;
    logic [PW-1:0] r_gap;
    logic [RW-1:0] r_rd_left;

    // Pending write of a shifted byte
    logic          r_wr_pend;
    logic [AW-1:0] r_wr_addr;

    // Output register
    logic r_out_valid;
    t_rsp r_out;

    logic [WW-1:0] pos_w;
    logic [WW-1:0] cnt_w;
    logic [WW-1:0] len_w;
    logic [WW-1:0] rem_w;
    logic [WW-1:0] ecnt_w;
    logic [WW-1:0] sat_w;
    logic [WW-1:0] rcnt_w;
    logic [WW-1:0] tgt_w;
    logic          past;
    logic          move_left;
    logic [PW-1:0] src_p;
    logic [PW-1:0] dst_p;
    logic [PW-1:0] phys_p;
    logic [AW-1:0] rd_addr;
    logic          rd_en;
    logic          out_free;
    logic          rd_last;

    // Clamp position and counts against the current text
    always_comb begin
        pos_w  = WW'(r_cmd.position);
        cnt_w  = WW'(r_cmd.count);
        len_w  = WW'(r_len);
        past   = (pos_w >= len_w);
        rem_w  = len_w - pos_w;
        ecnt_w = (cnt_w > rem_w) ? rem_w : cnt_w;
        sat_w  = (cnt_w > WW'(READ_MAX)) ? WW'(READ_MAX) : cnt_w;
        rcnt_w = (sat_w > rem_w) ? rem_w : sat_w;
        if (r_cmd.mode == MODE_INSERT) begin
            tgt_w = past ? len_w : pos_w;
        end else begin
            tgt_w = pos_w + ecnt_w;
        end
    end

    // Shift addresses for one gap step, and the read address
    always_comb begin
        move_left = (r_target < r_gs);
        src_p     = move_left ? (r_gs - PW'(1)) : r_ge;
        dst_p     = move_left ? (r_ge - PW'(1)) : r_gs;
        phys_p    = (r_lp < r_gs) ? r_lp : (r_lp + r_gap);
        rd_en     = i_ctl.move_step | i_ctl.rd_issue;
        rd_addr   = i_ctl.move_step ? src_p[AW-1:0] : phys_p[AW-1:0];
        out_free  = !r_out_valid || i_out_ready;
        rd_last   = (r_rd_left == RW'(1));
    end

    // Memory write: shifted byte first, else inserted byte
    always_ff @(posedge i_clk) begin
        if (r_wr_pend) begin
            r_mem[r_wr_addr] <= r_rd_data;
        end else if (i_ctl.ins_write) begin
            r_mem[r_gs[AW-1:0]] <= r_cmd.byte_in;
        end
    end

    // Memory read
    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    // Gap pointers, length and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gs        <= '0;
            r_ge        <= PW'(CAPACITY);
            r_len       <= '0;
            r_wr_pend   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_wr_pend <= i_ctl.move_step;
            if (i_ctl.move_step) begin
                if (move_left) begin
                    r_gs <= r_gs - PW'(1);
                    r_ge <= r_ge - PW'(1);
                end else begin
                    r_gs <= r_gs + PW'(1);
                    r_ge <= r_ge + PW'(1);
                end
            end else if (i_ctl.ins_write) begin
                r_gs  <= r_gs + PW'(1);
                r_len <= r_len + PW'(1);
            end else if (i_ctl.erase_set) begin
                r_gs  <= pos_w[PW-1:0];
                r_len <= r_len - r_ecnt;
            end
            if (i_ctl.rsp_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Command latch, decision values, read walk and output word
    always_ff @(posedge i_clk) begin
        if (i_ctl.load_cmd) begin
            r_cmd <= i_cmd;
        end
        if (i_ctl.decide) begin
            r_target  <= tgt_w[PW-1:0];
            r_ecnt    <= ecnt_w[PW-1:0];
            r_lp      <= pos_w[PW-1:0];
            r_gap     <= r_ge - r_gs;
            r_rd_left <= rcnt_w[RW-1:0];
        end
        if (i_ctl.move_step) begin
            r_wr_addr <= dst_p[AW-1:0];
        end
        if (i_ctl.rsp_load) begin
            r_out.byte_out    <= i_ctl.rsp_data ? r_rd_data : '0;
            r_out.status      <= i_ctl.rsp_status;
            r_out.last        <= i_ctl.rsp_data ? rd_last : 1'b1;
            r_out.text_length <= len_w[POS_W-1:0];
            if (i_ctl.rsp_data) begin
                r_lp      <= r_lp + PW'(1);
                r_rd_left <= r_rd_left - RW'(1);
            end
        end
    end

    always_comb begin
        o_sts.mode      = r_cmd.mode;
        o_sts.full      = (r_gs == r_ge);
        o_sts.past      = past;
        o_sts.cnt_zero  = (r_cmd.count == '0);
        o_sts.at_target = (r_gs == r_target);
        o_sts.rd_last   = rd_last;
        o_sts.out_free  = out_free;
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

### rtl/gbts_ctrl.sv
module gbts_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  gbts_pkg::t_sts i_sts,
    output gbts_pkg::t_ctl o_ctl
);
    import gbts_pkg::*;

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_DECIDE  = 4'd1;
    localparam logic [3:0] S_MOVE    = 4'd2;
    localparam logic [3:0] S_INS     = 4'd3;
    localparam logic [3:0] S_ERASE   = 4'd4;
    localparam logic [3:0] S_RESP    = 4'd5;
    localparam logic [3:0] S_RD_ADDR = 4'd6;
    localparam logic [3:0] S_RD_DATA = 4'd7;

    logic [3:0]        r_state;
    logic [3:0]        n_state;
    logic [STAT_W-1:0] r_status;
    logic [STAT_W-1:0] n_status;

    // Sequence one command
    always_comb begin
        n_state    = r_state;
        n_status   = r_status;
        o_ctl      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_ctl.load_cmd = 1'b1;
                    n_state        = S_DECIDE;
                end
            end
            S_DECIDE: begin
                o_ctl.decide = 1'b1;
                n_status     = ST_DONE;
                n_state      = S_RESP;
                case (i_sts.mode)
                    MODE_INSERT: begin
                        if (i_sts.full) begin
                            n_status = ST_FULL;
                        end else begin
                            n_state = S_MOVE;
                        end
                    end
                    MODE_ERASE: begin
                        if (i_sts.cnt_zero || i_sts.past) begin
                            n_status = ST_NONE;
                        end else begin
                            n_state = S_MOVE;
                        end
                    end
                    MODE_READ: begin
                        if (i_sts.cnt_zero || i_sts.past) begin
                            n_status = ST_NONE;
                        end else begin
                            n_state = S_RD_ADDR;
                        end
                    end
                    default: begin
                        n_status = ST_NONE;
                    end
                endcase
            end
            S_MOVE: begin
                // Shift one byte per cycle until the gap sits at the edit point
                if (i_sts.at_target) begin
                    n_state = (i_sts.mode == MODE_INSERT) ? S_INS : S_ERASE;
                end else begin
                    o_ctl.move_step = 1'b1;
                end
            end
            S_INS: begin
                o_ctl.ins_write = 1'b1;
                n_state         = S_RESP;
            end
            S_ERASE: begin
                o_ctl.erase_set = 1'b1;
                n_state         = S_RESP;
            end
            S_RESP: begin
                o_ctl.rsp_status = r_status;
                if (i_sts.out_free) begin
                    o_ctl.rsp_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            S_RD_ADDR: begin
                // Issue a read only when the output slot is free next cycle
                if (i_sts.out_free) begin
                    o_ctl.rd_issue = 1'b1;
                    n_state        = S_RD_DATA;
                end
            end
            S_RD_DATA: begin
                o_ctl.rsp_load   = 1'b1;
                o_ctl.rsp_data   = 1'b1;
                o_ctl.rsp_status = ST_DONE;
                n_state          = i_sts.rd_last ? S_IDLE : S_RD_ADDR;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_status <= ST_DONE;
        end else begin
            r_state  <= n_state;
            r_status <= n_status;
        end
    end

endmodule

### rtl/gap_buffer_text_store_unit.sv
// Gap-buffer text store.
// i_cmd takes one command word (mode, position, count, byte_in); o_rsp returns
// result words (byte_out, status, last, text_length), valid/ready on both sides.
// Insert and erase give one word; a read gives one word per byte, the final
// one marked by last; empty or out-of-range reads and erases give one word,
// status 2. An insert or erase first moves the gap to the edit point, one
// byte per cycle through the text memory's single read and write port; a
// read fetches each byte from memory, then registers it for output. A new
// command is taken once the previous one has placed its last word in the
// output register.
// Reset empties the text: the whole buffer becomes gap; no memory clearing.
// If the receiver stalls, the output register holds its word and the unit
// waits; one new command can still be taken while a word waits.
module gap_buffer_text_store_unit #(
    parameter int CAPACITY = gbts_pkg::CAPACITY_DEF,
    parameter int READ_MAX = gbts_pkg::READ_MAX_DEF
) (
    input logic          i_clk,
    input logic          i_rst_n,
    gbts_stream_if.sink   i_cmd,
    gbts_stream_if.source o_rsp
);
    import gbts_pkg::*;

    t_ctl w_ctl;
    t_sts w_sts;
    logic w_in_ready;
    logic w_out_valid;
    t_rsp w_out;

    gbts_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_cmd.valid),
        .o_in_ready (w_in_ready),
        .i_sts      (w_sts),
        .o_ctl      (w_ctl)
    );

    gbts_dp #(
        .CAPACITY (CAPACITY),
        .READ_MAX (READ_MAX)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (i_cmd.data),
        .i_ctl       (w_ctl),
        .o_sts       (w_sts),
        .i_out_ready (o_rsp.ready),
        .o_out_valid (w_out_valid),
        .o_out       (w_out)
    );

    assign i_cmd.ready = w_in_ready;
    assign o_rsp.valid = w_out_valid;
    assign o_rsp.data  = w_out;

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;

    import gbts_pkg::*;

    localparam int CAPACITY = CAPACITY_DEF;
    localparam int READ_MAX = READ_MAX_DEF;
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
    localparam int APPEND_WORDS = 40;
    localparam int RANDOM_WORDS = 96;
    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN_CYCLES = 64;

    // Text model: the logical text as a byte queue, plus the words it predicts
    class text_store_scoreboard;
        logic [BYTE_W-1:0] text_q[$];
        t_rsp expected_q[$];
        int errors;

        function new();
            errors = 0;
        endfunction

        function int length();
            return text_q.size();
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        task report(string msg);
            $display("ERROR @%0t: %s", $realtime, msg);
            errors++;
        endtask

        function void push_word(logic [BYTE_W-1:0] b, logic [STAT_W-1:0] st, logic lst);
            t_rsp r;
            r.byte_out = b;
            r.status = st;
            r.last = lst;
            r.text_length = POS_W'(text_q.size());
            expected_q.insert(expected_q.size(), r);
        endfunction

        // Predict the words caused by one accepted command word
        function void note_cmd(t_cmd c);
            int len;
            int pos;
            int cnt;
            int n;
            len = text_q.size();
            pos = int'(c.position);
            cnt = int'(c.count);
            case (c.mode)
                MODE_INSERT: begin
                    if (len == CAPACITY) begin
                        push_word('0, ST_FULL, 1'b1);
                    end else begin
                        if (pos > len) pos = len;
                        text_q.insert(pos, c.byte_in);
                        push_word('0, ST_DONE, 1'b1);
                    end
                end
                MODE_ERASE: begin
                    if (cnt == 0 || pos >= len) begin
                        push_word('0, ST_NONE, 1'b1);
                    end else begin
                        if (cnt > len - pos) cnt = len - pos;
                        repeat (cnt) text_q.delete(pos);
                        push_word('0, ST_DONE, 1'b1);
                    end
                end
                MODE_READ: begin
                    n = (cnt > READ_MAX) ? READ_MAX : cnt;
                    if (n == 0 || pos >= len) begin
                        push_word('0, ST_NONE, 1'b1);
                    end else begin
                        if (n > len - pos) n = len - pos;
                        for (int i = 0; i < n; i++) begin
                            push_word(text_q[pos + i], ST_DONE, (i + 1 == n));
                        end
                    end
                end
                default: begin
                    push_word('0, ST_NONE, 1'b1);
                end
            endcase
        endfunction

        // Compare one accepted result word with the oldest prediction
        task check_rsp(t_rsp got);
            t_rsp want;
            if (expected_q.size() == 0) begin
                report($sformatf("unexpected word byte=%0h status=%0d last=%0b len=%0d",
                                 got.byte_out, got.status, got.last, got.text_length));
                return;
            end
            want = expected_q.pop_front();
            if (got.byte_out !== want.byte_out)
                report($sformatf("byte_out expected %0h got %0h",
                                 want.byte_out, got.byte_out));
            if (got.status !== want.status)
                report($sformatf("status expected %0d got %0d", want.status, got.status));
            if (got.last !== want.last)
                report($sformatf("last expected %0b got %0b", want.last, got.last));
            if (got.text_length !== want.text_length)
                report($sformatf("text_length expected %0d got %0d",
                                 want.text_length, got.text_length));
        endtask
    endclass

    logic i_clk;
    logic i_rst_n;
    bit   idle_on;
    bit   hold_rsp;

    gbts_stream_if #(.t_data(t_cmd)) cmd_if ();
    gbts_stream_if #(.t_data(t_rsp)) rsp_if ();

    text_store_scoreboard sb;

    gap_buffer_text_store_unit u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_if.sink),
        .o_rsp   (rsp_if.source)
    );

    // Clock
    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    // Pick an idle gap: mostly none or short, a few long
    function automatic int rand_gap();
        int r;
        if (!idle_on) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Offer one command word and hold it until accepted
    task automatic issue(input logic [MODE_W-1:0] mode, input int pos, input int cnt,
                         input int b);
        t_cmd c;
        int gap;
        c.mode = mode;
        c.position = POS_W'(pos);
        c.count = CNT_W'(cnt);
        c.byte_in = BYTE_W'(b);
        gap = rand_gap();
        if (gap > 0) begin
            cmd_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        cmd_if.valid <= 1'b1;
        cmd_if.data <= c;
        @(posedge i_clk);
        while (!cmd_if.ready) @(posedge i_clk);
    endtask

    // Position: mostly inside the text, some just past the end, some anywhere
    function automatic int pick_pos(int len);
        int r;
        r = $urandom_range(0, 99);
        if (r < 80) return $urandom_range(0, len);
        if (r < 90) return len + $urandom_range(0, 5);
        return $urandom_range(0, 2047);
    endfunction

    // Monitor both channels; drain results before noting the new command
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (rsp_if.valid && rsp_if.ready) sb.check_rsp(rsp_if.data);
            if (cmd_if.valid && cmd_if.ready) sb.note_cmd(cmd_if.data);
        end
    end

    // Result receiver: random stalls, one long hold-off on request
    initial begin : receiver
        int stall;
        rsp_if.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_rsp) begin
                hold_rsp = 1'b0;
                rsp_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                stall = rand_gap();
                if (stall > 0) begin
                    rsp_if.ready <= 1'b0;
                    repeat (stall) @(posedge i_clk);
                end
                rsp_if.ready <= 1'b1;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
            end
        end
    end

    // Watchdog
    initial begin : watchdog
        #20_000_000;
        $display("gap_buffer_text_store_unit regression: fail");
        $finish;
    end

    // Stimulus
    initial begin : stimulus
        int len;
        int r;
        int cnt;
        sb = new();
        idle_on = 1'b1;
        hold_rsp = 1'b0;
        i_rst_n <= 1'b0;
        cmd_if.valid <= 1'b0;
        cmd_if.data <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Empty text: reads, erases and the unused mode do nothing
        issue(MODE_READ, 0, 5, 8'h11);
        issue(MODE_ERASE, 0, 1, 8'h22);
        issue(MODE_UNUSED, 0, 0, 8'h00);
        // Insert past the end clamps; extremes of the byte
        issue(MODE_INSERT, 2047, 0, 8'hFF);
        issue(MODE_INSERT, 0, 2047, 8'h00);
        issue(MODE_INSERT, 1, 0, 8'hA5);
        issue(MODE_READ, 0, 0, 8'h00);
        issue(MODE_READ, 0, 2047, 8'hFF);
        issue(MODE_READ, 3, 1, 8'h00);
        issue(MODE_ERASE, 1, 0, 8'h00);
        // Erase past the end clamps the count
        issue(MODE_ERASE, 2, 2047, 8'h00);
        issue(MODE_ERASE, 2047, 1, 8'h00);
        issue(MODE_UNUSED, 2047, 2047, 8'hFF);

        // Build a longer text by appending back to back
        idle_on = 1'b0;
        for (int i = 2; i < APPEND_WORDS + 2; i++) begin
            issue(MODE_INSERT, i, $urandom_range(0, 2047), $urandom_range(0, 255));
        end
        idle_on = 1'b1;

        // Reads that reach the end of the text
        issue(MODE_READ, 30, 2047, 8'h00);
        issue(MODE_READ, 0, READ_MAX, 8'h00);
        issue(MODE_READ, APPEND_WORDS + 1, 1, 8'h00);
        issue(MODE_UNUSED, 5, 5, 8'h00);
        // Far gap moves across the whole text
        issue(MODE_ERASE, APPEND_WORDS + 1, 1, 8'h00);
        issue(MODE_INSERT, 0, 0, 8'h3C);
        issue(MODE_READ, 0, READ_MAX, 8'h00);
        issue(MODE_ERASE, 0, 30, 8'h00);
        issue(MODE_READ, 0, 2047, 8'h00);

        // Random edits and reads on a modest text
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            if (n == 30) hold_rsp = 1'b1;
            idle_on = !(n >= 60 && n < 80);
            len = sb.length();
            r = $urandom_range(0, 99);
            if (len < 16) r = r / 2;
            else if (len > 200) r = (r < 30) ? 45 + r : r;
            if (r < 45) begin
                issue(MODE_INSERT, pick_pos(len), $urandom_range(0, 2047),
                      $urandom_range(0, 255));
            end else if (r < 65) begin
                cnt = $urandom_range(0, 99);
                if (cnt < 80) cnt = $urandom_range(1, 6);
                else if (cnt < 90) cnt = 0;
                else cnt = $urandom_range(0, 2047);
                issue(MODE_ERASE, pick_pos(len), cnt, $urandom_range(0, 255));
            end else if (r < 90) begin
                cnt = $urandom_range(0, 99);
                if (cnt < 75) cnt = $urandom_range(1, READ_MAX);
                else if (cnt < 85) cnt = $urandom_range(READ_MAX + 1, 2047);
                else if (cnt < 90) cnt = 0;
                else cnt = $urandom_range(0, 2047);
                issue(MODE_READ, pick_pos(len), cnt, $urandom_range(0, 255));
            end else if (r < 93) begin
                issue(MODE_UNUSED, $urandom_range(0, 2047), $urandom_range(0, 2047),
                      $urandom_range(0, 255));
            end else begin
                issue(MODE_W'($urandom_range(0, 3)), $urandom_range(0, 2047),
                      $urandom_range(0, 2047), $urandom_range(0, 255));
            end
        end
        cmd_if.valid <= 1'b0;
        // Let the monitor note the final command word
        @(posedge i_clk);

        // Drain outstanding words, then let the block settle
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.pending() != 0) sb.report("words still expected at end of run");

        if (sb.errors == 0) begin
            $display("gap_buffer_text_store_unit regression: pass");
        end else begin
            $display("gap_buffer_text_store_unit regression: fail");
        end
        $finish;
    end

endmodule
